>>> hdl/fmkf_pkg.sv
// Shared types and constants for the FN modifier key filter.
`timescale 1ns / 1ps

package fmkf_pkg;

  // Input codes and event constants
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_VOL  = 2'd1;
  localparam logic [1:0] OP_PAD  = 2'd2;

  localparam logic [1:0] KIND_FWD    = 2'd0;
  localparam logic [1:0] KIND_VOL    = 2'd1;
  localparam logic [1:0] KIND_BRIGHT = 2'd2;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [4:0] EVT_SYN = 5'd0;
  localparam logic [4:0] EVT_KEY = 5'd1;

  localparam logic [9:0] FN_CODE       = 10'd316;
  localparam logic [9:0] VOL_UP_CODE   = 10'd115;
  localparam logic [9:0] VOL_DOWN_CODE = 10'd114;

  localparam logic signed [31:0] KEY_RELEASE = 32'sd0;
  localparam logic signed [31:0] KEY_PRESS   = 32'sd1;
  localparam logic signed [31:0] KEY_REPEAT  = 32'sd2;

  // Register indexes on the configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKLIGHT_MAX     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKLIGHT_PRESENT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_REPEAT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHT_REPEAT     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TAP_HOLD          = 3'd5;

  // Reset values of the registers
  localparam logic [15:0] BACKLIGHT_MAX_RST  = 16'd255;
  localparam logic [15:0] REPEAT_DELAY_RST   = 16'd400;
  localparam logic [15:0] VOLUME_REPEAT_RST  = 16'd250;
  localparam logic [15:0] BRIGHT_REPEAT_RST  = 16'd200;
  localparam logic [15:0] TAP_HOLD_RST       = 16'd300;

  // Brightness step is max/10: exact for 16-bit values as (x * 52429) >> 19
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;
  localparam logic [15:0] BRIGHT_STEP_RST = 16'd25;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [4:0]         event_type;
    logic [9:0]         event_code;
    logic signed [31:0] event_value;
    logic [15:0]        current_brightness;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [4:0]         out_type;
    logic [9:0]         out_code;
    logic signed [31:0] out_value;
    logic               step_up;
    logic [15:0]        new_brightness;
    logic               last_of_run;
  } out_item_t;

  typedef out_item_t [MAX_RESULTS-1:0] res_set_t;

  typedef struct packed {
    logic [15:0] backlight_max;
    logic        backlight_present;
    logic [15:0] repeat_delay_ticks;
    logic [15:0] volume_repeat_ticks;
    logic [15:0] bright_repeat_ticks;
    logic [15:0] tap_hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic       fn_down;
    logic       fn_consumed;
    logic       fn_sent;
    logic [1:0] repeat_dir;
  } flags_t;

endpackage

>>> hdl/fmkf_core.sv
// Per-item event logic: next state and up to three results for one input item.
`timescale 1ns / 1ps

module fmkf_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  fmkf_pkg::in_item_t       item,
  input  fmkf_pkg::cfg_t           cfg,
  input  logic [15:0]              bright_step,
  input  fmkf_pkg::flags_t         flags,
  input  logic [TIMER_WIDTH-1:0]   tap_left,
  input  logic [TIMER_WIDTH-1:0]   rep_left,
  output fmkf_pkg::flags_t         flags_next,
  output logic [TIMER_WIDTH-1:0]   tap_left_next,
  output logic [TIMER_WIDTH-1:0]   rep_left_next,
  output fmkf_pkg::res_set_t       res,
  output logic [1:0]               res_count
);

  localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = {{(TIMER_WIDTH-1){1'b0}}, 1'b1};

  // Load a timer from a 16-bit register; a zero load counts as one tick
  function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [15:0] v);
    logic [TIMER_WIDTH+15:0] ext;
    logic [TIMER_WIDTH-1:0]  m;
    ext = {{TIMER_WIDTH{1'b0}}, v};
    m   = ext[TIMER_WIDTH-1:0];
    return (m == '0) ? TIMER_ONE : m;
  endfunction

  // Step the backlight level and clamp to 1..max
  function automatic logic [15:0] bright_calc(input logic up, input logic [15:0] cur,
                                              input logic [15:0] st,
                                              input logic [15:0] mx);
    logic signed [17:0] nv;
    logic signed [17:0] mxs;
    mxs = signed'({2'b00, mx});
    nv  = up ? signed'({2'b00, cur}) + signed'({2'b00, st})
             : signed'({2'b00, cur}) - signed'({2'b00, st});
    if (nv > mxs) nv = mxs;
    if (nv < 18'sd1) nv = 18'sd1;
    return nv[15:0];
  endfunction

  function automatic fmkf_pkg::out_item_t make_fwd(input logic [4:0] t, input logic [9:0] c,
                                                   input logic signed [31:0] v);
    fmkf_pkg::out_item_t r;
    r             = '0;
    r.result_kind = fmkf_pkg::KIND_FWD;
    r.out_type    = t;
    r.out_code    = c;
    r.out_value   = v;
    return r;
  endfunction

  logic                   is_key;
  logic                   step_now;
  logic [1:0]             step_dir;
  logic [1:0]             vol_dir;
  logic [TIMER_WIDTH-1:0] cnt;
  fmkf_pkg::out_item_t    step_res;

  assign is_key = (item.event_type == fmkf_pkg::EVT_KEY);

  always_comb begin
    flags_next    = flags;
    tap_left_next = tap_left;
    rep_left_next = rep_left;
    res           = '0;
    res_count     = 2'd0;
    step_now      = 1'b0;
    step_dir      = flags.repeat_dir;
    vol_dir       = (item.event_code == fmkf_pkg::VOL_UP_CODE) ? fmkf_pkg::DIR_UP
                                                               : fmkf_pkg::DIR_DOWN;
    cnt           = rep_left;
    step_res      = '0;

    case (item.opcode)
      fmkf_pkg::OP_TICK: begin
        // Count down a pending tap release
        if (tap_left != '0) begin
          tap_left_next = tap_left - TIMER_ONE;
          if (tap_left == TIMER_ONE) begin
            res[0]    = make_fwd(fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE, fmkf_pkg::KEY_RELEASE);
            res[1]    = make_fwd(fmkf_pkg::EVT_SYN, 10'd0, 32'sd0);
            res_count = 2'd2;
          end
        end
        // Advance the held-key repeat
        if (flags.repeat_dir != fmkf_pkg::DIR_NONE) begin
          if (cnt != '0) cnt = cnt - TIMER_ONE;
          rep_left_next = cnt;
          if (cnt == '0) begin
            step_now      = 1'b1;
            step_dir      = flags.repeat_dir;
            rep_left_next = timer_load(flags.fn_down ? cfg.bright_repeat_ticks
                                                     : cfg.volume_repeat_ticks);
          end
        end
      end

      fmkf_pkg::OP_VOL: begin
        if (is_key && item.event_value != fmkf_pkg::KEY_REPEAT &&
            (item.event_code == fmkf_pkg::VOL_UP_CODE ||
             item.event_code == fmkf_pkg::VOL_DOWN_CODE)) begin
          if (item.event_value == fmkf_pkg::KEY_PRESS) begin
            flags_next.repeat_dir = vol_dir;
            step_now              = 1'b1;
            step_dir              = vol_dir;
            rep_left_next         = timer_load(cfg.repeat_delay_ticks);
          end else if (flags.repeat_dir == vol_dir) begin
            flags_next.repeat_dir = fmkf_pkg::DIR_NONE;
          end
        end
      end

      fmkf_pkg::OP_PAD: begin
        if (is_key && item.event_code == fmkf_pkg::FN_CODE) begin
          if (item.event_value == fmkf_pkg::KEY_PRESS) begin
            // Flush a pending tap release before the new hold
            if (tap_left != '0) begin
              res[0]        = make_fwd(fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                                       fmkf_pkg::KEY_RELEASE);
              res[1]        = make_fwd(fmkf_pkg::EVT_SYN, 10'd0, 32'sd0);
              res_count     = 2'd2;
              tap_left_next = '0;
            end
            flags_next.fn_down     = 1'b1;
            flags_next.fn_consumed = 1'b0;
            flags_next.fn_sent     = 1'b0;
          end else if (item.event_value == fmkf_pkg::KEY_RELEASE) begin
            flags_next.fn_down = 1'b0;
            if (flags.fn_sent) begin
              res[0]             = make_fwd(fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                                            fmkf_pkg::KEY_RELEASE);
              res[1]             = make_fwd(fmkf_pkg::EVT_SYN, 10'd0, 32'sd0);
              res_count          = 2'd2;
              flags_next.fn_sent = 1'b0;
            end else if (!flags.fn_consumed) begin
              // Replay a bare tap as a timed press
              res[0]        = make_fwd(fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                                       fmkf_pkg::KEY_PRESS);
              res[1]        = make_fwd(fmkf_pkg::EVT_SYN, 10'd0, 32'sd0);
              res_count     = 2'd2;
              tap_left_next = timer_load(cfg.tap_hold_ticks);
            end
          end
        end else begin
          // Send a held FN just ahead of the first other button
          if (is_key && item.event_value == fmkf_pkg::KEY_PRESS && flags.fn_down &&
              !flags.fn_sent && !flags.fn_consumed) begin
            res[0]             = make_fwd(fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                                          fmkf_pkg::KEY_PRESS);
            res[1]             = make_fwd(fmkf_pkg::EVT_SYN, 10'd0, 32'sd0);
            res_count          = 2'd2;
            flags_next.fn_sent = 1'b1;
          end
          res[res_count] = make_fwd(item.event_type, item.event_code, item.event_value);
          res_count      = res_count + 2'd1;
        end
      end

      default: begin
      end
    endcase

    // Volume step or brightness write
    if (step_now) begin
      if (flags.fn_down) begin
        flags_next.fn_consumed = 1'b1;
        if (cfg.backlight_present) begin
          step_res.result_kind    = fmkf_pkg::KIND_BRIGHT;
          step_res.new_brightness = bright_calc(step_dir == fmkf_pkg::DIR_UP,
                                                item.current_brightness, bright_step,
                                                cfg.backlight_max);
          res[res_count]          = step_res;
          res_count               = res_count + 2'd1;
        end
      end else begin
        step_res.result_kind = fmkf_pkg::KIND_VOL;
        step_res.step_up     = (step_dir == fmkf_pkg::DIR_UP);
        res[res_count]       = step_res;
        res_count            = res_count + 2'd1;
      end
    end

    // Mark the final result of the run
    if (res_count != 2'd0) res[res_count - 2'd1].last_of_run = 1'b1;
  end

endmodule

>>> hdl/fn_modifier_key_filter.sv
// Top level of the FN modifier key filter: registers, state and result queue.
`timescale 1ns / 1ps

// One input item (a 1 ms tick, a volume-key event or a gamepad event) is taken
// per transfer and worked in the same cycle into up to three results, which
// go into a four-entry result queue and leave one per cycle on the output
// channel while out_ready is high. An item is taken while the queue holds at
// most one result, so a stream of items runs at one item per cycle when items
// make at most one result and out_ready stays high; an item that makes more
// holds off the next one until the queue is down to one result. Configuration
// writes take effect at the next clock; the user must make them only while the
// block is idle, as the block itself does not enforce it. The brightness step
// (backlight_max / 10, at least 1) is worked out when backlight_max is written.
module fn_modifier_key_filter #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  fmkf_pkg::in_item_t                      in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output fmkf_pkg::out_item_t                     out_data,
  input  logic                                    cfg_we,
  input  logic [fmkf_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [15:0]                             cfg_data
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  fmkf_pkg::cfg_t         cfg;
  logic [15:0]            bright_step;
  logic [32:0]            div_prod;
  logic [15:0]            div_quot;

  fmkf_pkg::flags_t       flags;
  fmkf_pkg::flags_t       flags_next;
  logic [TIMER_WIDTH-1:0] tap_left;
  logic [TIMER_WIDTH-1:0] tap_left_next;
  logic [TIMER_WIDTH-1:0] rep_left;
  logic [TIMER_WIDTH-1:0] rep_left_next;
  fmkf_pkg::res_set_t     res;
  logic [1:0]             res_count;

  fmkf_pkg::out_item_t    queue [QDEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QPTR_W:0]        count;
  logic [QPTR_W:0]        count_next;
  logic                   in_xfer;
  logic                   out_xfer;
  logic [1:0]             push_n;

  // Brightness step from backlight_max via reciprocal multiply
  assign div_prod = {17'd0, cfg_data} * {16'd0, fmkf_pkg::DIV10_MUL};
  assign div_quot = {2'b00, div_prod[32:fmkf_pkg::DIV10_SHIFT]};

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.backlight_max       <= fmkf_pkg::BACKLIGHT_MAX_RST;
      cfg.backlight_present   <= 1'b0;
      cfg.repeat_delay_ticks  <= fmkf_pkg::REPEAT_DELAY_RST;
      cfg.volume_repeat_ticks <= fmkf_pkg::VOLUME_REPEAT_RST;
      cfg.bright_repeat_ticks <= fmkf_pkg::BRIGHT_REPEAT_RST;
      cfg.tap_hold_ticks      <= fmkf_pkg::TAP_HOLD_RST;
      bright_step             <= fmkf_pkg::BRIGHT_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fmkf_pkg::REG_BACKLIGHT_MAX: begin
          cfg.backlight_max <= cfg_data;
          bright_step       <= (div_quot == 16'd0) ? 16'd1 : div_quot;
        end
        fmkf_pkg::REG_BACKLIGHT_PRESENT: cfg.backlight_present   <= cfg_data[0];
        fmkf_pkg::REG_REPEAT_DELAY:      cfg.repeat_delay_ticks  <= cfg_data;
        fmkf_pkg::REG_VOLUME_REPEAT:     cfg.volume_repeat_ticks <= cfg_data;
        fmkf_pkg::REG_BRIGHT_REPEAT:     cfg.bright_repeat_ticks <= cfg_data;
        fmkf_pkg::REG_TAP_HOLD:          cfg.tap_hold_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fmkf_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .item          (in_data),
    .cfg           (cfg),
    .bright_step   (bright_step),
    .flags         (flags),
    .tap_left      (tap_left),
    .rep_left      (rep_left),
    .flags_next    (flags_next),
    .tap_left_next (tap_left_next),
    .rep_left_next (rep_left_next),
    .res           (res),
    .res_count     (res_count)
  );

  // Take an item only when the queue has room for a full run
  assign in_ready  = (count <= (QPTR_W+1)'(1));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_xfer  = out_valid && out_ready;
  assign out_data  = queue[rd_ptr];
  assign push_n    = in_xfer ? res_count : 2'd0;

  always_comb begin
    count_next = count + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(out_xfer);
  end

  // Advance the filter state on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      flags    <= '0;
      tap_left <= '0;
      rep_left <= '0;
    end else if (in_xfer) begin
      flags    <= flags_next;
      tap_left <= tap_left_next;
      rep_left <= rep_left_next;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push_n);
      if (out_xfer) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count_next;
    end
  end

  // Write the run of results into the queue
  always_ff @(posedge clk) begin
    for (int i = 0; i < fmkf_pkg::MAX_RESULTS; i++) begin
      if (in_xfer && (i < int'(res_count))) begin
        queue[wr_ptr + QPTR_W'(i)] <= res[i];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_sent_needs_down: assert property (@(posedge clk) disable iff (rst)
    flags.fn_sent |-> flags.fn_down)
    else $error("FN marked forwarded while not held");

  a_tap_needs_up: assert property (@(posedge clk) disable iff (rst)
    (tap_left != '0) |-> !flags.fn_down)
    else $error("tap release pending while FN held");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !in_xfer |=> (flags == $past(flags)) && (tap_left == $past(tap_left)))
    else $error("filter state changed without an input transfer");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the FN modifier key filter: directed and random event streams.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam logic [4:0] EVT_ABS        = 5'd3;
  localparam logic [9:0] BTN_SOUTH_CODE = 10'd304;
  localparam int unsigned IDLE_PCT      = 17;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 4000;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  fmkf_pkg::in_item_t               in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  fmkf_pkg::out_item_t              out_data;
  logic                             cfg_we = 1'b0;
  logic [fmkf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]                      cfg_data = '0;

  logic no_idle = 1'b0;
  int   mismatch_count = 0;
  int   stall_cycles = 0;

  // Register copies, at their reset values
  logic [15:0] bl_max       = fmkf_pkg::BACKLIGHT_MAX_RST;
  logic        bl_present   = 1'b0;
  logic [15:0] delay_ticks  = fmkf_pkg::REPEAT_DELAY_RST;
  logic [15:0] vol_ticks    = fmkf_pkg::VOLUME_REPEAT_RST;
  logic [15:0] bright_ticks = fmkf_pkg::BRIGHT_REPEAT_RST;
  logic [15:0] tap_ticks    = fmkf_pkg::TAP_HOLD_RST;

  // Filter state, at its reset values
  logic        fn_held          = 1'b0;
  logic        fn_used          = 1'b0;
  logic        fn_relayed       = 1'b0;
  logic [15:0] tap_countdown    = '0;
  logic [1:0]  rep_dir          = fmkf_pkg::DIR_NONE;
  logic [15:0] repeat_countdown = '0;

  fmkf_pkg::out_item_t run_buf [fmkf_pkg::MAX_RESULTS];
  int                  run_n;
  fmkf_pkg::out_item_t due_outputs [$];

  fn_modifier_key_filter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the output side at random
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Filter model
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] load_timer(logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  task automatic add_result(logic [1:0] kind, logic [4:0] ev_type, logic [9:0] ev_code,
                            logic signed [31:0] ev_value, logic up, logic [15:0] level);
    fmkf_pkg::out_item_t r;
    r.result_kind    = kind;
    r.out_type       = ev_type;
    r.out_code       = ev_code;
    r.out_value      = ev_value;
    r.step_up        = up;
    r.new_brightness = level;
    r.last_of_run    = 1'b0;
    run_buf[run_n]   = r;
    run_n++;
  endtask

  task automatic add_fn_pair(logic signed [31:0] value);
    add_result(fmkf_pkg::KIND_FWD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE, value, 1'b0, 16'd0);
    add_result(fmkf_pkg::KIND_FWD, fmkf_pkg::EVT_SYN, 10'd0, 32'sd0, 1'b0, 16'd0);
  endtask

  // Volume step, or brightness step while FN is held
  task automatic apply_step(logic [1:0] dir, logic [15:0] cur);
    int st;
    int nv;
    if (fn_held) begin
      fn_used = 1'b1;
      if (bl_present) begin
        st = int'(bl_max) / 10;
        if (st < 1) st = 1;
        nv = int'(cur);
        if (dir == fmkf_pkg::DIR_UP) nv = nv + st;
        else nv = nv - st;
        if (nv > int'(bl_max)) nv = int'(bl_max);
        if (nv < 1) nv = 1;
        add_result(fmkf_pkg::KIND_BRIGHT, fmkf_pkg::EVT_SYN, 10'd0, 32'sd0, 1'b0, nv[15:0]);
      end
    end else begin
      add_result(fmkf_pkg::KIND_VOL, fmkf_pkg::EVT_SYN, 10'd0, 32'sd0,
                 dir == fmkf_pkg::DIR_UP, 16'd0);
    end
  endtask

  task automatic filter_event(fmkf_pkg::in_item_t it);
    logic [1:0] dir;
    run_n = 0;
    case (it.opcode)
      fmkf_pkg::OP_TICK: begin
        if (tap_countdown != 16'd0) begin
          tap_countdown--;
          if (tap_countdown == 16'd0) add_fn_pair(fmkf_pkg::KEY_RELEASE);
        end
        if (rep_dir != fmkf_pkg::DIR_NONE) begin
          if (repeat_countdown > 16'd0) repeat_countdown--;
          if (repeat_countdown == 16'd0) begin
            apply_step(rep_dir, it.current_brightness);
            repeat_countdown = load_timer(fn_held ? bright_ticks : vol_ticks);
          end
        end
      end
      fmkf_pkg::OP_VOL: begin
        if (it.event_type == fmkf_pkg::EVT_KEY && it.event_value != fmkf_pkg::KEY_REPEAT &&
            (it.event_code == fmkf_pkg::VOL_UP_CODE ||
             it.event_code == fmkf_pkg::VOL_DOWN_CODE)) begin
          dir = (it.event_code == fmkf_pkg::VOL_UP_CODE) ? fmkf_pkg::DIR_UP
                                                         : fmkf_pkg::DIR_DOWN;
          if (it.event_value == fmkf_pkg::KEY_PRESS) begin
            rep_dir = dir;
            apply_step(dir, it.current_brightness);
            repeat_countdown = load_timer(delay_ticks);
          end else if (rep_dir == dir) begin
            rep_dir = fmkf_pkg::DIR_NONE;
          end
        end
      end
      fmkf_pkg::OP_PAD: begin
        if (it.event_type == fmkf_pkg::EVT_KEY && it.event_code == fmkf_pkg::FN_CODE) begin
          if (it.event_value == fmkf_pkg::KEY_PRESS) begin
            // A new press cuts a replayed tap short
            if (tap_countdown != 16'd0) begin
              add_fn_pair(fmkf_pkg::KEY_RELEASE);
              tap_countdown = 16'd0;
            end
            fn_held    = 1'b1;
            fn_used    = 1'b0;
            fn_relayed = 1'b0;
          end else if (it.event_value == fmkf_pkg::KEY_RELEASE) begin
            fn_held = 1'b0;
            if (fn_relayed) begin
              add_fn_pair(fmkf_pkg::KEY_RELEASE);
              fn_relayed = 1'b0;
            end else if (!fn_used) begin
              add_fn_pair(fmkf_pkg::KEY_PRESS);
              tap_countdown = load_timer(tap_ticks);
            end
          end
        end else begin
          // Forward a held FN just ahead of the first other button press
          if (it.event_type == fmkf_pkg::EVT_KEY && it.event_value == fmkf_pkg::KEY_PRESS &&
              fn_held && !fn_relayed && !fn_used) begin
            add_fn_pair(fmkf_pkg::KEY_PRESS);
            fn_relayed = 1'b1;
          end
          add_result(fmkf_pkg::KIND_FWD, it.event_type, it.event_code, it.event_value,
                     1'b0, 16'd0);
        end
      end
      default: ;
    endcase
    for (int i = 0; i < run_n; i++) begin
      if (i == run_n - 1) run_buf[i].last_of_run = 1'b1;
      due_outputs.push_back(run_buf[i]);
    end
  endtask

  task automatic check_output(fmkf_pkg::out_item_t got);
    fmkf_pkg::out_item_t want;
    if (due_outputs.size() == 0) begin
      report_mismatch("result with nothing pending, kind", 32'(got.result_kind), 32'd0);
    end else begin
      want = due_outputs.pop_front();
      if (got.result_kind != want.result_kind)
        report_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
      if (got.out_type != want.out_type)
        report_mismatch("out_type", 32'(got.out_type), 32'(want.out_type));
      if (got.out_code != want.out_code)
        report_mismatch("out_code", 32'(got.out_code), 32'(want.out_code));
      if (got.out_value != want.out_value)
        report_mismatch("out_value", got.out_value, want.out_value);
      if (got.step_up != want.step_up)
        report_mismatch("step_up", 32'(got.step_up), 32'(want.step_up));
      if (got.new_brightness != want.new_brightness)
        report_mismatch("new_brightness", 32'(got.new_brightness),
                        32'(want.new_brightness));
      if (got.last_of_run != want.last_of_run)
        report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    end
  endtask

  // Check each output transfer, then model each input transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_output(out_data);
      if (in_valid && in_ready) filter_event(in_data);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL fn_modifier_key_filter");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic fmkf_pkg::in_item_t make_item(logic [1:0] op, logic [4:0] ev_type,
                                                   logic [9:0] ev_code,
                                                   logic signed [31:0] ev_value,
                                                   logic [15:0] cur);
    fmkf_pkg::in_item_t it;
    it.opcode             = op;
    it.event_type         = ev_type;
    it.event_code         = ev_code;
    it.event_value        = ev_value;
    it.current_brightness = cur;
    return it;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(fmkf_pkg::in_item_t it);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every predicted output
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [fmkf_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      fmkf_pkg::REG_BACKLIGHT_MAX:     bl_max       = val;
      fmkf_pkg::REG_BACKLIGHT_PRESENT: bl_present   = val[0];
      fmkf_pkg::REG_REPEAT_DELAY:      delay_ticks  = val;
      fmkf_pkg::REG_VOLUME_REPEAT:     vol_ticks    = val;
      fmkf_pkg::REG_BRIGHT_REPEAT:     bright_ticks = val;
      fmkf_pkg::REG_TAP_HOLD:          tap_ticks    = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reprogram every register once the block has gone quiet
  task automatic write_config(logic [15:0] max_level, logic [15:0] present,
                              logic [15:0] delay, logic [15:0] vol_rep,
                              logic [15:0] bright_rep, logic [15:0] tap_hold);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(fmkf_pkg::REG_BACKLIGHT_MAX, max_level);
    write_reg(fmkf_pkg::REG_BACKLIGHT_PRESENT, present);
    write_reg(fmkf_pkg::REG_REPEAT_DELAY, delay);
    write_reg(fmkf_pkg::REG_VOLUME_REPEAT, vol_rep);
    write_reg(fmkf_pkg::REG_BRIGHT_REPEAT, bright_rep);
    write_reg(fmkf_pkg::REG_TAP_HOLD, tap_hold);
  endtask

  function automatic logic [15:0] random_level();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2: return bl_max + 16'($urandom_range(8)) - 16'd4;
      default: return 16'($urandom_range(20));
    endcase
  endfunction

  // Mostly well-formed key traffic and ticks, with some raw noise
  function automatic fmkf_pkg::in_item_t random_event();
    fmkf_pkg::in_item_t it;
    int unsigned        pick;
    int unsigned        sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    it.opcode             = fmkf_pkg::OP_TICK;
    it.event_type         = 5'($urandom);
    it.event_code         = 10'($urandom);
    it.event_value        = 32'($urandom);
    it.current_brightness = random_level();
    if (pick < 35) begin
      it.opcode = fmkf_pkg::OP_TICK;
    end else if (pick < 52) begin
      it.opcode      = fmkf_pkg::OP_VOL;
      it.event_type  = fmkf_pkg::EVT_KEY;
      it.event_code  = $urandom_range(1) ? fmkf_pkg::VOL_UP_CODE : fmkf_pkg::VOL_DOWN_CODE;
      it.event_value = (sub < 60) ? fmkf_pkg::KEY_PRESS
                     : (sub < 90) ? fmkf_pkg::KEY_RELEASE : fmkf_pkg::KEY_REPEAT;
    end else if (pick < 67) begin
      it.opcode     = fmkf_pkg::OP_PAD;
      it.event_type = fmkf_pkg::EVT_KEY;
      it.event_code = fmkf_pkg::FN_CODE;
      if (sub < 45) it.event_value = fmkf_pkg::KEY_PRESS;
      else if (sub < 90) it.event_value = fmkf_pkg::KEY_RELEASE;
    end else if (pick < 87) begin
      it.opcode      = fmkf_pkg::OP_PAD;
      it.event_type  = fmkf_pkg::EVT_KEY;
      it.event_value = (sub < 45) ? fmkf_pkg::KEY_PRESS
                     : (sub < 90) ? fmkf_pkg::KEY_RELEASE : fmkf_pkg::KEY_REPEAT;
    end else begin
      it.opcode = 2'($urandom);
    end
    return it;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_item(random_event());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: no backlight, long timers
  task automatic test_defaults();
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_UP_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd100));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_DOWN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd100));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_DOWN_CODE,
                        fmkf_pkg::KEY_REPEAT, 16'd100));
    // odd value counts as a release
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_DOWN_CODE,
                        32'sh8000_0000, 16'd0));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_SYN, fmkf_pkg::VOL_UP_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, 10'h3FF,
                        fmkf_pkg::KEY_PRESS, 16'hFFFF));
    // tap, then a new press sends the pending release at once
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    // FN as modifier without a backlight: swallowed
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_UP_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd50));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_UP_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd50));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd0));
    // FN held across a button press is forwarded ahead of it
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, BTN_SOUTH_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_REPEAT, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, 5'h1F, 10'h3FF, 32'sh7FFF_FFFF, 16'hFFFF));
    send_item(make_item(OP_UNUSED, 5'h1F, 10'h3FF, 32'shFFFF_FFFF, 16'hFFFF));
  endtask

  // Brightness clamps at both ends, then a replayed tap that times out
  task automatic test_brightness();
    write_config(16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_UP_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd65530));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_DOWN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd3));
    send_item(make_item(fmkf_pkg::OP_VOL, fmkf_pkg::EVT_KEY, fmkf_pkg::VOL_DOWN_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd3));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_PRESS, 16'd0));
    send_item(make_item(fmkf_pkg::OP_PAD, fmkf_pkg::EVT_KEY, fmkf_pkg::FN_CODE,
                        fmkf_pkg::KEY_RELEASE, 16'd0));
    send_item(make_item(fmkf_pkg::OP_TICK, fmkf_pkg::EVT_SYN, 10'd0, 32'sd0, 16'd0));
    send_item(make_item(fmkf_pkg::OP_TICK, fmkf_pkg::EVT_SYN, 10'd0, 32'sd0, 16'd0));
  endtask

  task automatic test_min_backlight();
    write_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
    send_random(30);
  endtask

  task automatic test_no_idle_stretch();
    write_config(16'hFFFF, 16'hFFFF, 16'd3, 16'd2, 16'd4, 16'd5);
    no_idle = 1'b1;
    send_random(30);
    no_idle = 1'b0;
  endtask

  // Timer registers of zero behave as one
  task automatic test_zero_intervals();
    write_config(16'd9, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0);
    send_random(30);
  endtask

  task automatic test_long_timers();
    write_config(fmkf_pkg::BACKLIGHT_MAX_RST, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_random(30);
  endtask

  // Sender holds off mid-stream until all outputs are out
  task automatic test_sender_pause();
    write_config(16'($urandom_range(1, 65535)), 16'd1, 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                 16'($urandom_range(1, 6)));
    send_random(25);
    wait_results_drained();
    send_random(25);
  endtask

  task automatic test_random_settings();
    write_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1)),
                 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
    send_random(30);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_defaults();
    test_brightness();
    test_min_backlight();
    test_no_idle_stretch();
    test_zero_intervals();
    test_long_timers();
    test_sender_pause();
    test_random_settings();

    // Drain and let any stray output show up
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_outputs.size() != 0)
      report_mismatch("outputs never produced", 32'(due_outputs.size()), 32'd0);
    if (mismatch_count == 0) begin
      $display("PASS fn_modifier_key_filter");
    end else begin
      $display("FAIL fn_modifier_key_filter");
    end
    $finish;
  end

endmodule
